// ----- hdl/lfuc_pkg.sv -----
// Shared types and constants for the LFU cache with LRU tie-break.
`default_nettype none

package lfuc_pkg;

    localparam int CAP_W  = 5;
    localparam int KEY_W  = 32;
    localparam int DATA_W = 31;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_EVICT,
        ST_INSERT,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

// ----- hdl/lfu_cache_with_lru_tiebreak.sv -----
// Top level of the LFU key-value cache with least-recently-used tie-break.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one word per item: a get or
//   put opcode, a 32-bit key and a 31-bit value for puts. Output channel
//   (o_out_valid / i_out_ready) returns one word per item: found and the value
//   held for the key before the item (zero on a miss).
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes capacity_in_use;
//   it is always ready. Zero acts as one, values above MAX_ENTRIES clamp.
// Timing:
//   Every item sweeps all MAX_ENTRIES slots through one read port of the
//   entry memory, one slot per cycle, with a single compare unit tracking the
//   hit, the first free slot and the eviction candidate. After the sweep a
//   decide state sends a get miss straight to the result, a hit through an
//   update state, a put into a free slot through an insert state and a put
//   that evicts through an evict state, then an insert state. A new item is
//   accepted in the cycle after the result is loaded, not during a sweep.
// Reset clears all valid bits, the occupancy and the state machine, and sets
// the capacity to 16. No clearing pass is needed. When the receiver stalls,
// the result holds in the output register; a following item is still taken
// and swept, and it waits in its final state until the output register frees.
`default_nettype none

module lfu_cache_with_lru_tiebreak #(
    parameter int MAX_ENTRIES = 16,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // item input
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic                         i_opcode,
    input  wire logic [lfuc_pkg::KEY_W-1:0]   i_key,
    input  wire logic [lfuc_pkg::DATA_W-1:0]  i_write_value,
    // result output
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_found,
    output logic [lfuc_pkg::DATA_W-1:0]       o_read_value,
    // configuration write
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [lfuc_pkg::CAP_W-1:0]   i_capacity_in_use
);
    import lfuc_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

    // Sequencer state
    t_state r_state, n_state;

    // Configuration and occupancy
    logic [CAP_W-1:0] r_cap;
    logic [OCC_W-1:0] r_occ;

    // Per-slot cells: valid bit and recency rank (0 = most recent)
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [IDX_W-1:0]       r_rank [MAX_ENTRIES];

    // Entry memory: key, value, use count
    logic [KEY_W-1:0]      mem_key  [MAX_ENTRIES];
    logic [DATA_W-1:0]     mem_data [MAX_ENTRIES];
    logic [COUNT_BITS-1:0] mem_cnt  [MAX_ENTRIES];
    logic [KEY_W-1:0]      r_rd_key;
    logic [DATA_W-1:0]     r_rd_data;
    logic [COUNT_BITS-1:0] r_rd_cnt;

    // Latched item
    logic              r_op;
    logic [KEY_W-1:0]  r_key;
    logic [DATA_W-1:0] r_wval;

    // Sweep control
    logic [IDX_W-1:0] r_addr;
    logic             r_issued;
    logic             r_cmp_en;
    logic [IDX_W-1:0] r_cmp_idx;

    // Sweep results
    logic                  r_hit;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [DATA_W-1:0]     r_hit_data;
    logic [COUNT_BITS-1:0] r_hit_cnt;
    logic [IDX_W-1:0]      r_hit_rank;
    logic                  r_free;
    logic [IDX_W-1:0]      r_free_idx;
    logic                  r_vic;
    logic [IDX_W-1:0]      r_vic_idx;
    logic [COUNT_BITS-1:0] r_vic_cnt;
    logic [IDX_W-1:0]      r_vic_rank;
    logic [IDX_W-1:0]      r_slot;

    // Output register
    logic              r_out_valid;
    logic              r_out_found;
    logic [DATA_W-1:0] r_out_data;

    // Combinational control
    logic                  in_accept;
    logic                  scan_last;
    logic                  cmp_valid;
    logic [IDX_W-1:0]      cmp_rank;
    logic                  key_match;
    logic                  vic_better;
    logic [CMP_W-1:0]      eff_cap;
    logic                  cache_full;
    logic                  out_free;
    logic                  load_out;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_wa;
    logic [DATA_W-1:0]     mem_wdata;
    logic [COUNT_BITS-1:0] mem_wcnt;
    logic [COUNT_BITS-1:0] hit_cnt_inc;

    assign o_cfg_ready = 1'b1;

    assign in_accept = i_in_valid && o_in_ready;
    assign scan_last = r_cmp_en && (r_cmp_idx == LAST_IDX);
    assign out_free  = !r_out_valid || i_out_ready;

    // The compare unit sees one slot per cycle: the registered memory word
    // and the matching valid bit and rank.
    assign cmp_valid  = r_valid[r_cmp_idx];
    assign cmp_rank   = r_rank[r_cmp_idx];
    assign key_match  = cmp_valid && (r_rd_key == r_key);
    // Lower count wins; on equal count the older (larger rank) wins.
    assign vic_better = cmp_valid && (!r_vic || (r_rd_cnt < r_vic_cnt) ||
                        ((r_rd_cnt == r_vic_cnt) && (cmp_rank > r_vic_rank)));

    // Effective capacity: zero acts as one, clamp at the slot count.
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = CMP_W'(1);
        end else if (CMP_W'(r_cap) > CMP_W'(MAX_ENTRIES)) begin
            eff_cap = CMP_W'(MAX_ENTRIES);
        end else begin
            eff_cap = CMP_W'(r_cap);
        end
    end
    assign cache_full = CMP_W'(r_occ) >= eff_cap;

    // Saturating use count
    assign hit_cnt_inc = (&r_hit_cnt) ? r_hit_cnt : r_hit_cnt + COUNT_BITS'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (r_hit) begin
                    n_state = ST_UPDATE;
                end else if (r_op == OP_PUT) begin
                    n_state = cache_full ? ST_EVICT : ST_INSERT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_UPDATE: n_state = ST_DONE;
            ST_EVICT:  n_state = ST_INSERT;
            ST_INSERT: n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_ready = 1'b0;
        load_out   = 1'b0;
        mem_we     = 1'b0;
        mem_wa     = r_slot;
        mem_wdata  = r_wval;
        mem_wcnt   = COUNT_BITS'(1);
        case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_UPDATE: begin
                mem_we    = 1'b1;
                mem_wa    = r_hit_idx;
                mem_wdata = (r_op == OP_PUT) ? r_wval : r_hit_data;
                mem_wcnt  = hit_cnt_inc;
            end
            ST_INSERT: mem_we = 1'b1;
            ST_DONE:   load_out = out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cap       <= CAP_RESET;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
            r_issued    <= 1'b0;
            r_cmp_en    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cap <= i_capacity_in_use;
            end
            // issue one read per cycle, drop issue after the last slot
            r_cmp_en <= (r_state == ST_SCAN) && !r_issued;
            if (in_accept) begin
                r_issued <= 1'b0;
            end else if ((r_state == ST_SCAN) && (r_addr == LAST_IDX)) begin
                r_issued <= 1'b1;
            end
            if (r_state == ST_EVICT) begin
                r_occ <= r_occ - OCC_W'(1);
            end else if (r_state == ST_INSERT) begin
                r_occ <= r_occ + OCC_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (r_state == ST_EVICT) begin
            r_valid[r_vic_idx] <= 1'b0;
        end else if (r_state == ST_INSERT) begin
            r_valid[r_slot] <= 1'b1;
        end
    end

    // Recency cells: each slot ages or rejuvenates against a broadcast rank
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            case (r_state)
                ST_UPDATE: begin
                    if (IDX_W'(i) == r_hit_idx) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i] && (r_rank[i] < r_hit_rank)) begin
                        r_rank[i] <= r_rank[i] + IDX_W'(1);
                    end
                end
                ST_EVICT: begin
                    if (r_valid[i] && (r_rank[i] > r_vic_rank)) begin
                        r_rank[i] <= r_rank[i] - IDX_W'(1);
                    end
                end
                ST_INSERT: begin
                    if (IDX_W'(i) == r_slot) begin
                        r_rank[i] <= '0;
                    end else if (r_valid[i]) begin
                        r_rank[i] <= r_rank[i] + IDX_W'(1);
                    end
                end
                default: begin
                    r_rank[i] <= r_rank[i];
                end
            endcase
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_key[mem_wa]  <= r_key;
            mem_data[mem_wa] <= mem_wdata;
            mem_cnt[mem_wa]  <= mem_wcnt;
        end
        r_rd_key  <= mem_key[r_addr];
        r_rd_data <= mem_data[r_addr];
        r_rd_cnt  <= mem_cnt[r_addr];
    end

    // Item latch, sweep address and sweep results
    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_addr;
        if (in_accept) begin
            r_op   <= i_opcode;
            r_key  <= i_key;
            r_wval <= i_write_value;
            r_addr <= '0;
            r_hit  <= 1'b0;
            r_free <= 1'b0;
            r_vic  <= 1'b0;
        end else begin
            if ((r_state == ST_SCAN) && (r_addr != LAST_IDX)) begin
                r_addr <= r_addr + IDX_W'(1);
            end
            if (r_cmp_en) begin
                if (key_match && !r_hit) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_cmp_idx;
                    r_hit_data <= r_rd_data;
                    r_hit_cnt  <= r_rd_cnt;
                    r_hit_rank <= cmp_rank;
                end
                if (!cmp_valid && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_cmp_idx;
                end
                if (vic_better) begin
                    r_vic      <= 1'b1;
                    r_vic_idx  <= r_cmp_idx;
                    r_vic_cnt  <= r_rd_cnt;
                    r_vic_rank <= cmp_rank;
                end
            end
        end
        // insert at the lowest free slot once the victim is gone
        if (r_state == ST_DECIDE) begin
            if (cache_full) begin
                r_slot <= (r_free && (r_free_idx < r_vic_idx)) ? r_free_idx : r_vic_idx;
            end else begin
                r_slot <= r_free_idx;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_found <= r_hit;
            r_out_data  <= r_hit ? r_hit_data : '0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_out_found;
    assign o_read_value = r_out_data;

endmodule

`default_nettype wire
